// ===== hw/rtl/xsr_pkg.sv =====
// Shared constants, command codes and control structs of the xoshiro256** generator.
package xsr_pkg;

  // Splitmix64 constants used on reseed.
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  // Field widths.
  localparam int KIND_W  = 2;
  localparam int BOUND_W = 63;
  localparam int WORD_W  = 64;

  // The fraction request drops this many low bits of a draw.
  localparam int FRAC_SHIFT = 11;

  // One remainder bit per step of the serial divider.
  localparam int DIV_STEPS = WORD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_RESEED  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RAW     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRAC    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BOUNDED = 2'd3;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_SM_ADV,
    OP_MUL_LL,
    OP_MUL_LH,
    OP_MUL_HL,
    OP_SM_MIX,
    OP_SM_STORE,
    OP_DRAW,
    OP_DIV_LOAD_THR,
    OP_DIV_LOAD_DRAW,
    OP_DIV_STEP,
    OP_THR_SAVE,
    OP_OUT_LOAD
  } xsr_op_t;

  // Source of the result value.
  typedef enum logic [1:0] {
    RES_ZERO,
    RES_RAW,
    RES_FRAC,
    RES_REM
  } xsr_res_t;

  // Command bundle from controller to datapath.
  typedef struct packed {
    xsr_op_t    op;
    logic [1:0] word_idx;
    logic       mul_sel;
    xsr_res_t   res_sel;
    logic       err;
  } xsr_cmd_t;

  // Status bundle from datapath to controller.
  typedef struct packed {
    logic draw_lt_thr;
  } xsr_stat_t;

endpackage

// ===== hw/rtl/xsr_if.sv =====
// Request and result channel interfaces of the generator.
interface xsr_req_if
  import xsr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [BOUND_W-1:0] bound;

  modport source (output valid, kind, bound, input ready);
  modport sink   (input valid, kind, bound, output ready);
endinterface

interface xsr_rsp_if
  import xsr_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] value;
  logic              status;

  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// ===== hw/rtl/xsr_ctrl.sv =====
// Controller state machine sequencing reseed, draws and the serial divider.
module xsr_ctrl
  import xsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  input  logic              in_bound_zero,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  xsr_stat_t         stat,
  output xsr_cmd_t          cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_MUL,
    S_MIX,
    S_STORE,
    S_DRAW,
    S_TLOAD,
    S_TDIV,
    S_TSAVE,
    S_CHECK,
    S_VLOAD,
    S_VDIV,
    S_FINISH
  } state_t;

  state_t            state_r;
  logic [1:0]        word_r;
  logic [1:0]        phase_r;
  logic              msel_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [KIND_W-1:0] kind_r;
  logic              err_r;
  logic              init_r;
  logic              out_valid_r;

  logic in_fire;
  logic out_free;
  logic cnt_last;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign cnt_last  = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // Command decode from the current state.
  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.word_idx = word_r;
    cmd.mul_sel  = msel_r;
    cmd.err      = err_r;
    cmd.res_sel  = RES_ZERO;
    case (kind_r)
      KIND_RAW:     cmd.res_sel = RES_RAW;
      KIND_FRAC:    cmd.res_sel = RES_FRAC;
      KIND_BOUNDED: cmd.res_sel = err_r ? RES_ZERO : RES_REM;
      default:      cmd.res_sel = RES_ZERO;
    endcase
    case (state_r)
      S_IDLE:   cmd.op = in_fire ? OP_CAPTURE : OP_NONE;
      S_ADV:    cmd.op = OP_SM_ADV;
      S_MUL: begin
        case (phase_r)
          2'd0:    cmd.op = OP_MUL_LL;
          2'd1:    cmd.op = OP_MUL_LH;
          default: cmd.op = OP_MUL_HL;
        endcase
      end
      S_MIX:    cmd.op = OP_SM_MIX;
      S_STORE:  cmd.op = OP_SM_STORE;
      S_DRAW:   cmd.op = OP_DRAW;
      S_TLOAD:  cmd.op = OP_DIV_LOAD_THR;
      S_TDIV:   cmd.op = OP_DIV_STEP;
      S_TSAVE:  cmd.op = OP_THR_SAVE;
      S_CHECK:  cmd.op = OP_NONE;
      S_VLOAD:  cmd.op = OP_DIV_LOAD_DRAW;
      S_VDIV:   cmd.op = OP_DIV_STEP;
      S_FINISH: cmd.op = out_free ? OP_OUT_LOAD : OP_NONE;
      default:  cmd.op = OP_NONE;
    endcase
  end

  // State and registered outputs. Reset runs the seed-zero expansion first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ADV;
      word_r      <= 2'd0;
      phase_r     <= 2'd0;
      msel_r      <= 1'b0;
      cnt_r       <= '0;
      kind_r      <= KIND_RESEED;
      err_r       <= 1'b0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      // The result register empties when its beat is taken.
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            kind_r <= in_kind;
            err_r  <= 1'b0;
            word_r <= 2'd0;
            msel_r <= 1'b0;
            case (in_kind)
              KIND_RESEED: state_r <= S_ADV;
              KIND_RAW:    state_r <= S_DRAW;
              KIND_FRAC:   state_r <= S_DRAW;
              default: begin
                if (in_bound_zero) begin
                  err_r   <= 1'b1;
                  state_r <= S_FINISH;
                end else begin
                  state_r <= S_TLOAD;
                end
              end
            endcase
          end
        end
        S_ADV: begin
          phase_r <= 2'd0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          if (phase_r == 2'd2) begin
            phase_r <= 2'd0;
            state_r <= msel_r ? S_STORE : S_MIX;
          end else begin
            phase_r <= phase_r + 2'd1;
          end
        end
        S_MIX: begin
          msel_r  <= 1'b1;
          state_r <= S_MUL;
        end
        S_STORE: begin
          msel_r <= 1'b0;
          if (word_r == 2'd3) begin
            word_r  <= 2'd0;
            init_r  <= 1'b0;
            state_r <= init_r ? S_IDLE : S_FINISH;
          end else begin
            word_r  <= word_r + 2'd1;
            state_r <= S_ADV;
          end
        end
        S_DRAW: begin
          state_r <= (kind_r == KIND_BOUNDED) ? S_CHECK : S_FINISH;
        end
        S_TLOAD: begin
          cnt_r   <= '0;
          state_r <= S_TDIV;
        end
        S_TDIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_last) begin
            state_r <= S_TSAVE;
          end
        end
        S_TSAVE: begin
          state_r <= S_DRAW;
        end
        S_CHECK: begin
          state_r <= stat.draw_lt_thr ? S_DRAW : S_VLOAD;
        end
        S_VLOAD: begin
          cnt_r   <= '0;
          state_r <= S_VDIV;
        end
        S_VDIV: begin
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_last) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/xsr_dp.sv =====
// Datapath: generator words, splitmix mixer, shared multiplier, serial divider, result register.
module xsr_dp
  import xsr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [WORD_W-1:0]  cfg_wdata,
  input  logic [BOUND_W-1:0] in_bound,
  input  xsr_cmd_t           cmd,
  output xsr_stat_t          stat,
  output logic [WORD_W-1:0]  out_value,
  output logic               out_status
);

  logic [WORD_W-1:0]  seed_r;
  logic [WORD_W-1:0]  acc_r;
  logic [WORD_W-1:0]  z_r;
  logic [WORD_W-1:0]  prod_r;
  logic [WORD_W-1:0]  words_r [4];
  logic [WORD_W-1:0]  draw_r;
  logic [WORD_W-1:0]  dvd_r;
  logic [BOUND_W-1:0] rem_r;
  logic [BOUND_W-1:0] thr_r;
  logic [BOUND_W-1:0] bound_r;
  logic [WORD_W-1:0]  value_r;
  logic               status_r;

  logic [WORD_W-1:0]   acc_nxt;
  logic [WORD_W-1:0]   mconst;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [WORD_W-1:0]   mp;
  logic [WORD_W-1:0]   t5;
  logic [WORD_W-1:0]   rot;
  logic [WORD_W-1:0]   draw_nxt;
  logic [WORD_W-1:0]   n0;
  logic [WORD_W-1:0]   n1;
  logic [WORD_W-1:0]   n2;
  logic [WORD_W-1:0]   n3;
  logic [WORD_W-1:0]   rem_sh;
  logic [WORD_W:0]     rem_diff;
  logic [WORD_W-1:0]   value_nxt;

  // Seed register, written only through the configuration port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // Shared 32x32 multiplier; a 64-bit low product takes three partial products.
  assign acc_nxt = acc_r + GOLDEN_STEP;
  assign mconst  = cmd.mul_sel ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a   = (cmd.op == OP_MUL_HL) ? z_r[63:32] : z_r[31:0];
  assign mul_b   = (cmd.op == OP_MUL_LH) ? mconst[63:32] : mconst[31:0];
  assign mp      = mul_a * mul_b;

  // xoshiro256** output and state update, from multiplies by 5 and 9 as shifts and adds.
  assign t5       = words_r[1] + (words_r[1] << 2);
  assign rot      = {t5[56:0], t5[63:57]};
  assign draw_nxt = rot + (rot << 3);
  assign n2       = words_r[2] ^ words_r[0];
  assign n3       = words_r[3] ^ words_r[1];
  assign n1       = words_r[1] ^ n2;
  assign n0       = words_r[0] ^ n3;

  // One restoring step of the remainder: bring down a bit, subtract if it fits.
  assign rem_sh   = {rem_r, dvd_r[WORD_W-1]};
  assign rem_diff = {1'b0, rem_sh} - {2'b00, bound_r};

  assign stat.draw_lt_thr = (draw_r < {1'b0, thr_r});

  // Result value selection.
  always_comb begin
    case (cmd.res_sel)
      RES_RAW:  value_nxt = draw_r;
      RES_FRAC: value_nxt = {{FRAC_SHIFT{1'b0}}, draw_r[WORD_W-1:FRAC_SHIFT]};
      RES_REM:  value_nxt = {1'b0, rem_r};
      default:  value_nxt = '0;
    endcase
  end

  // Splitmix accumulator; cleared by reset so the power-up expansion uses seed zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.op == OP_CAPTURE) begin
      acc_r <= seed_r;
    end else if (cmd.op == OP_SM_ADV) begin
      acc_r <= acc_nxt;
    end
  end

  // Payload registers driven by the command.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        bound_r <= in_bound;
      end
      OP_SM_ADV: begin
        z_r <= acc_nxt ^ (acc_nxt >> 30);
      end
      OP_MUL_LL: begin
        prod_r <= mp;
      end
      OP_MUL_LH, OP_MUL_HL: begin
        prod_r <= {prod_r[63:32] + mp[31:0], prod_r[31:0]};
      end
      OP_SM_MIX: begin
        z_r <= prod_r ^ (prod_r >> 27);
      end
      OP_SM_STORE: begin
        words_r[cmd.word_idx] <= prod_r ^ (prod_r >> 31);
      end
      OP_DRAW: begin
        draw_r     <= draw_nxt;
        words_r[0] <= n0;
        words_r[1] <= n1;
        words_r[2] <= n2 ^ (words_r[1] << 17);
        words_r[3] <= {n3[18:0], n3[63:19]};
      end
      OP_DIV_LOAD_THR: begin
        // The threshold is (2^64 - bound) mod bound.
        dvd_r <= '0 - {1'b0, bound_r};
        rem_r <= '0;
      end
      OP_DIV_LOAD_DRAW: begin
        dvd_r <= draw_r;
        rem_r <= '0;
      end
      OP_DIV_STEP: begin
        dvd_r <= dvd_r << 1;
        rem_r <= rem_diff[WORD_W] ? rem_sh[BOUND_W-1:0] : rem_diff[BOUND_W-1:0];
      end
      OP_THR_SAVE: begin
        thr_r <= rem_r;
      end
      OP_OUT_LOAD: begin
        value_r  <= value_nxt;
        status_r <= cmd.err;
      end
      default: begin
      end
    endcase
  end

  assign out_value  = value_r;
  assign out_status = status_r;

endmodule

// ===== hw/rtl/xoshiro_prng_bounded.sv =====
// A reseed expands four splitmix words, sharing one 32x32 multiplier.
// Bounded draws run two 64-step serial remainders and draw again after each rejection.
// Throughput: one item at a time; a new beat is taken while the last result waits.
// Reset (synchronous, rst_n low) clears the seed to zero, then expands it into the
// generator words before the first request is taken.
module xoshiro_prng_bounded
  import xsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  xsr_req_if.sink           in_chan,
  xsr_rsp_if.source         out_chan,
  input  logic              cfg_we,
  input  logic [WORD_W-1:0] cfg_wdata
);

  xsr_cmd_t  cmd;
  xsr_stat_t stat;
  logic      bound_zero;

  assign bound_zero = (in_chan.bound == '0);

  // Sequencer.
  xsr_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_chan.valid),
    .in_kind       (in_chan.kind),
    .in_bound_zero (bound_zero),
    .in_ready      (in_chan.ready),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // Arithmetic and storage.
  xsr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_bound   (in_chan.bound),
    .cmd        (cmd),
    .stat       (stat),
    .out_value  (out_chan.value),
    .out_status (out_chan.status)
  );

  // An accepted beat keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input accepted while the previous item was still in progress");

  // The result register is never overwritten while a beat is waiting in it.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_OUT_LOAD) |-> (!out_chan.valid || out_chan.ready))
    else $error("result register loaded over an untaken result");

  // An error result carries a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status) |-> (out_chan.value == '0))
    else $error("error result with a nonzero value");

  // A reseed request is checked not to finish too early after its accept.
  a_reseed_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && (in_chan.kind == KIND_RESEED)) |=> ##3 !in_chan.ready)
    else $error("reseed finished too early");

endmodule
